// ===== src/linear_probing_hash_table_core_assert.svh =====
// Assertion helpers for the hash table core
`ifndef LINEAR_PROBING_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBING_HASH_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LPHT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LPHT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lpht_pkg.sv =====
package lpht_pkg;

    // request modes
    localparam logic [1:0] MODE_PUT    = 2'd0;
    localparam logic [1:0] MODE_GET    = 2'd1;
    localparam logic [1:0] MODE_DEL    = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    // slot states
    localparam logic [1:0] SLOT_EMPTY = 2'd0;
    localparam logic [1:0] SLOT_FULL  = 2'd1;
    localparam logic [1:0] SLOT_TOMB  = 2'd2;

    // outcomes
    localparam logic [2:0] OC_INSERTED = 3'd0;
    localparam logic [2:0] OC_OVERFLOW = 3'd1;
    localparam logic [2:0] OC_FOUND    = 3'd2;
    localparam logic [2:0] OC_NOTFOUND = 3'd3;
    localparam logic [2:0] OC_REMOVED  = 3'd4;

    // register map (paddr[2])
    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic REG_HASH_BASE  = 1'b1;

    localparam logic [10:0] TABLE_SIZE_RESET = 11'd1024;
    localparam logic [9:0]  HASH_BASE_RESET  = 10'd31;

    // rank('a') = 1
    localparam logic [7:0] RANK_OFFSET = 8'h60;

    typedef logic [2:0] outcome_t;

endpackage

// ===== src/lpht_ram.sv =====
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/linear_probing_hash_table_core.sv =====
// Channel   Ports                                         Direction
// request   s_valid s_ready s_mode s_key_chars            in
//           s_key_length s_put_value
// result    m_valid m_ready m_hash_index m_outcome        out
//           m_probed m_final_slot m_result_value
// config    psel penable pwrite paddr pwdata prdata pready APB slave
//
// One request at a time. Hashing runs Horner's rule through one shared
// multiply and a bit-serial remainder unit: each key character takes a
// multiply step, then a bit-serial reduction modulo the effective table size,
// a modulus QW = clog2(TABLE_DEPTH+1) bits wide. Each slot visited takes a
// registered RAM read, then a check. After reset a clearing pass marks all
// TABLE_DEPTH slots empty, one per cycle; s_ready stays low until it ends.
// A stalled result holds the next request in its final cycle until the output register frees.
`include "linear_probing_hash_table_core_assert.svh"

module linear_probing_hash_table_core #(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_CHARS   = 8
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [63:0]        s_key_chars,
    input  logic [3:0]         s_key_length,
    input  logic signed [31:0] s_put_value,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [9:0]         m_hash_index,
    output logic [2:0]         m_outcome,
    output logic               m_probed,
    output logic [9:0]         m_final_slot,
    output logic signed [31:0] m_result_value,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int SW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int QW   = $clog2(TABLE_DEPTH + 1);
    localparam int DW   = QW + 10;
    localparam int BCW  = $clog2(DW);
    localparam int CIW  = (KEY_CHARS > 1) ? $clog2(KEY_CHARS) : 1;
    localparam int KB   = 8 * KEY_CHARS;
    localparam int DWID = KB + 36;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_RD   = 3'd4;
    localparam logic [2:0] ST_CHK  = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;

    // configuration
    logic [10:0] table_size_reg;
    logic [9:0]  hash_base_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= lpht_pkg::TABLE_SIZE_RESET;
            hash_base_reg  <= lpht_pkg::HASH_BASE_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == lpht_pkg::REG_HASH_BASE) begin
                hash_base_reg <= pwdata[9:0];
            end else begin
                table_size_reg <= pwdata[10:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == lpht_pkg::REG_HASH_BASE) begin
            prdata = {22'd0, hash_base_reg};
        end else begin
            prdata = {21'd0, table_size_reg};
        end
    end

    // effective modulus
    logic [QW-1:0] q_eff;
    always_comb begin
        if (table_size_reg == 11'd0) begin
            q_eff = QW'(1);
        end else if (32'(table_size_reg) > 32'(TABLE_DEPTH)) begin
            q_eff = QW'(TABLE_DEPTH);
        end else begin
            q_eff = QW'(table_size_reg);
        end
    end

    // datapath registers
    logic [2:0]        state_reg, state_next;
    logic [SW-1:0]     clr_addr_reg, clr_addr_next;
    logic [1:0]        mode_reg, mode_next;
    logic [KB-1:0]     key_reg, key_next;
    logic [3:0]        len_reg, len_next;
    logic [31:0]       val_reg, val_next;
    logic [CIW-1:0]    char_idx_reg, char_idx_next;
    logic [DW-1:0]     dividend_reg, dividend_next;
    logic [QW:0]       rem_reg, rem_next;
    logic [BCW-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [SW-1:0]     home_reg, home_next;
    logic [SW-1:0]     slot_reg, slot_next;
    logic [QW-1:0]     k_reg, k_next;
    logic              probed_reg, probed_next;
    lpht_pkg::outcome_t outcome_reg, outcome_next;
    logic [31:0]       rv_reg, rv_next;

    logic              m_valid_reg, m_valid_next;
    logic [9:0]        m_hash_index_reg, m_hash_index_next;
    logic [2:0]        m_outcome_reg, m_outcome_next;
    logic              m_probed_reg, m_probed_next;
    logic [9:0]        m_final_slot_reg, m_final_slot_next;
    logic [31:0]       m_result_value_reg, m_result_value_next;

    // memories
    logic              st_we;
    logic [SW-1:0]     st_waddr;
    logic [1:0]        st_wdata;
    logic [1:0]        st_rdata;
    logic              dt_we;
    logic [DWID-1:0]   dt_wdata;
    logic [DWID-1:0]   dt_rdata;

    lpht_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_state_ram (
        .clk     (aclk),
        .wr_en   (st_we),
        .wr_addr (st_waddr),
        .wr_data (st_wdata),
        .rd_addr (slot_reg),
        .rd_data (st_rdata)
    );

    lpht_ram #(.WIDTH(DWID), .DEPTH(TABLE_DEPTH)) u_data_ram (
        .clk     (aclk),
        .wr_en   (dt_we),
        .wr_addr (slot_reg),
        .wr_data (dt_wdata),
        .rd_addr (slot_reg),
        .rd_data (dt_rdata)
    );

    assign dt_wdata = {val_reg, len_reg, key_reg};

    // request capture helpers
    logic [3:0]    len_clamp;
    logic [KB-1:0] key_masked;
    always_comb begin
        len_clamp = (s_key_length > 4'(KEY_CHARS)) ? 4'(KEY_CHARS) : s_key_length;
        for (int b = 0; b < KEY_CHARS; b++) begin
            key_masked[b*8 +: 8] = (4'(b) < len_clamp) ? s_key_chars[b*8 +: 8] : 8'd0;
        end
    end

    // shared arithmetic
    logic [7:0]    rank;
    logic [DW-1:0] mac;
    logic [QW:0]   trial;
    logic          trial_ge;
    logic [QW:0]   trial_sub;
    assign rank      = key_reg[char_idx_reg*8 +: 8] - lpht_pkg::RANK_OFFSET;
    assign mac       = DW'(rem_reg[QW-1:0] * hash_base_reg) + DW'(rank);
    assign trial     = {rem_reg[QW-1:0], dividend_reg[DW-1]};
    assign trial_ge  = trial >= (QW+1)'(q_eff);
    assign trial_sub = trial - (QW+1)'(q_eff);

    // probe step helpers
    logic [SW:0]   slot_inc;
    logic [SW-1:0] slot_adv;
    logic [QW-1:0] k_inc;
    logic          walk_done;
    logic          key_hit;
    assign slot_inc  = {1'b0, slot_reg} + (SW+1)'(1);
    assign slot_adv  = (32'(slot_inc) == 32'(q_eff)) ? SW'(0) : slot_inc[SW-1:0];
    assign k_inc     = k_reg + QW'(1);
    assign walk_done = (k_inc == q_eff);
    assign key_hit   = (st_rdata == lpht_pkg::SLOT_FULL) &&
                       (dt_rdata[KB+3:KB] == len_reg) && (dt_rdata[KB-1:0] == key_reg);

    logic [SW+9:0] home_wide;
    logic [SW+9:0] slot_wide;
    assign home_wide = {10'd0, home_reg};
    assign slot_wide = {10'd0, slot_reg};

    always_comb begin
        state_next          = state_reg;
        clr_addr_next       = clr_addr_reg;
        mode_next           = mode_reg;
        key_next            = key_reg;
        len_next            = len_reg;
        val_next            = val_reg;
        char_idx_next       = char_idx_reg;
        dividend_next       = dividend_reg;
        rem_next            = rem_reg;
        bit_cnt_next        = bit_cnt_reg;
        home_next           = home_reg;
        slot_next           = slot_reg;
        k_next              = k_reg;
        probed_next         = probed_reg;
        outcome_next        = outcome_reg;
        rv_next             = rv_reg;
        m_valid_next        = m_valid_reg & ~m_ready;
        m_hash_index_next   = m_hash_index_reg;
        m_outcome_next      = m_outcome_reg;
        m_probed_next       = m_probed_reg;
        m_final_slot_next   = m_final_slot_reg;
        m_result_value_next = m_result_value_reg;
        st_we               = 1'b0;
        st_waddr            = slot_reg;
        st_wdata            = lpht_pkg::SLOT_EMPTY;
        dt_we               = 1'b0;

        unique case (state_reg)
            ST_CLR: begin
                st_we    = 1'b1;
                st_waddr = clr_addr_reg;
                if (32'(clr_addr_reg) == 32'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + SW'(1);
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next     = s_mode;
                    key_next      = key_masked;
                    len_next      = len_clamp;
                    val_next      = s_put_value;
                    rem_next      = '0;
                    char_idx_next = CIW'(len_clamp - 4'd1);
                    k_next        = '0;
                    probed_next   = 1'b0;
                    outcome_next  = lpht_pkg::OC_NOTFOUND;
                    rv_next       = '0;
                    if (len_clamp == 4'd0) begin
                        // empty key hashes to slot 0
                        home_next  = '0;
                        slot_next  = '0;
                        state_next = (s_mode == lpht_pkg::MODE_UNUSED) ? ST_FIN : ST_RD;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                // Horner step: h*base + rank, then reduce
                dividend_next = mac;
                rem_next      = '0;
                bit_cnt_next  = BCW'(DW - 1);
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                rem_next      = trial_ge ? trial_sub : trial;
                dividend_next = {dividend_reg[DW-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg - BCW'(1);
                if (bit_cnt_reg == '0) begin
                    if (char_idx_reg == '0) begin
                        home_next  = SW'(rem_next[QW-1:0]);
                        slot_next  = SW'(rem_next[QW-1:0]);
                        state_next = (mode_reg == lpht_pkg::MODE_UNUSED) ? ST_FIN : ST_RD;
                    end else begin
                        char_idx_next = char_idx_reg - CIW'(1);
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (mode_reg == lpht_pkg::MODE_PUT) begin
                    // home slot takes tombstones, later slots only empties
                    if ((k_reg == '0) ? (st_rdata != lpht_pkg::SLOT_FULL)
                                      : (st_rdata == lpht_pkg::SLOT_EMPTY)) begin
                        st_we        = 1'b1;
                        st_wdata     = lpht_pkg::SLOT_FULL;
                        dt_we        = 1'b1;
                        outcome_next = lpht_pkg::OC_INSERTED;
                        rv_next      = val_reg;
                        state_next   = ST_FIN;
                    end else begin
                        probed_next = 1'b1;
                        k_next      = k_inc;
                        slot_next   = slot_adv;
                        if (walk_done) begin
                            outcome_next = lpht_pkg::OC_OVERFLOW;
                            state_next   = ST_FIN;
                        end else begin
                            state_next = ST_RD;
                        end
                    end
                end else if (key_hit) begin
                    if (mode_reg == lpht_pkg::MODE_GET) begin
                        outcome_next = lpht_pkg::OC_FOUND;
                        rv_next      = dt_rdata[KB+35:KB+4];
                    end else begin
                        st_we        = 1'b1;
                        st_wdata     = lpht_pkg::SLOT_TOMB;
                        outcome_next = lpht_pkg::OC_REMOVED;
                    end
                    state_next = ST_FIN;
                end else if (st_rdata == lpht_pkg::SLOT_EMPTY) begin
                    state_next = ST_FIN;
                end else begin
                    probed_next = 1'b1;
                    k_next      = k_inc;
                    slot_next   = slot_adv;
                    state_next  = walk_done ? ST_FIN : ST_RD;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_hash_index_next   = home_wide[9:0];
                    m_outcome_next      = outcome_reg;
                    m_probed_next       = probed_reg;
                    m_final_slot_next   = slot_wide[9:0];
                    m_result_value_next = rv_reg;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            clr_addr_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg           <= mode_next;
        key_reg            <= key_next;
        len_reg            <= len_next;
        val_reg            <= val_next;
        char_idx_reg       <= char_idx_next;
        dividend_reg       <= dividend_next;
        rem_reg            <= rem_next;
        bit_cnt_reg        <= bit_cnt_next;
        home_reg           <= home_next;
        slot_reg           <= slot_next;
        k_reg              <= k_next;
        probed_reg         <= probed_next;
        outcome_reg        <= outcome_next;
        rv_reg             <= rv_next;
        m_hash_index_reg   <= m_hash_index_next;
        m_outcome_reg      <= m_outcome_next;
        m_probed_reg       <= m_probed_next;
        m_final_slot_reg   <= m_final_slot_next;
        m_result_value_reg <= m_result_value_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_hash_index   = m_hash_index_reg;
    assign m_outcome      = m_outcome_reg;
    assign m_probed       = m_probed_reg;
    assign m_final_slot   = m_final_slot_reg;
    assign m_result_value = m_result_value_reg;

    `LPHT_ASSERT_NXT(a_one_request, aclk, aresetn, s_valid && s_ready, !s_ready, "request taken while busy")
    `LPHT_ASSERT_IMP(a_rem_bound, aclk, aresetn, state_reg == ST_DIV, rem_reg < (QW+1)'(q_eff), "remainder not reduced")
    `LPHT_ASSERT_IMP(a_walk_bound, aclk, aresetn, state_reg == ST_RD, k_reg < q_eff, "probe count past table size")
    `LPHT_ASSERT_IMP(a_no_write_idle, aclk, aresetn, state_reg == ST_IDLE, !st_we && !dt_we, "table written while idle")

endmodule
